### hw/rtl/itc_pkg.sv
// Shared constants for the incremental transitive closure block.
package itc_pkg;

  localparam int VERTEX_COUNT_DEF = 16;
  localparam int VERTEX_W         = 4;
  localparam int KIND_W           = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RECOMPUTE = 2'd2;

endpackage

### hw/rtl/itc_ram.sv
// Simple dual-port RAM: one write port, one read port with registered read data.
module itc_ram #(
  parameter int  DEPTH = itc_pkg::VERTEX_COUNT_DEF,
  parameter int  WIDTH = itc_pkg::VERTEX_COUNT_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/incremental_transitive_closure_top.sv
// Top level of the incremental transitive closure engine.
//
// The block holds an adjacency bit matrix and a reachability bit matrix, one row per vertex,
// each in a RAM with one write port and one registered read port. A command is taken when
// start is high and busy is low; busy then stays high until the command is done, and exactly
// one result follows on out_valid for a single cycle, which the receiver must take. The work
// is a sweep of the reachability RAM at one row per cycle, so the read port sets the rate. A
// query or an out-of-range insert only reads the answer row, a repeated edge in directed
// mode also reads the adjacency row, and a new edge insert sweeps once, and once more in
// undirected mode (an undirected insert always performs the reverse sweep). A recompute
// loads reachability from adjacency and sweeps once per vertex. After reset no clearing pass
// is needed: a valid bit per row makes an unwritten row read as its reset value (no edges,
// and the vertex reaching only itself), so commands are taken right away. The undirected
// mode register may only be written while busy is low and no result is pending.
module incremental_transitive_closure_top #(
  parameter int VERTEX_COUNT = itc_pkg::VERTEX_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [itc_pkg::KIND_W-1:0]    in_kind,
  input  logic [itc_pkg::VERTEX_W-1:0]  in_source_vertex,
  input  logic [itc_pkg::VERTEX_W-1:0]  in_target_vertex,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  output logic                          out_valid,
  output logic                          out_reachable,
  output logic                          out_edge_was_new
);

  import itc_pkg::*;

  localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam logic [AW-1:0]           LAST    = AW'(VERTEX_COUNT - 1);
  localparam logic [VERTEX_COUNT-1:0] ROW_ONE = VERTEX_COUNT'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FWD_ADJ,
    ST_FWD_CHK,
    ST_REV_ADJ,
    ST_REV_CHK,
    ST_INIT_PRE,
    ST_INIT,
    ST_KEY,
    ST_KEY_LAT,
    ST_SWEEP,
    ST_RES_RD,
    ST_RES
  } state_t;

  typedef enum logic [1:0] {
    PH_FWD,
    PH_REV,
    PH_CLOSE
  } phase_t;

  state_t                  state_r, state_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [KIND_W-1:0]       kind_r, kind_nxt;
  logic [AW-1:0]           src_r, src_nxt;
  logic [AW-1:0]           tgt_r, tgt_nxt;
  logic                    ok_r, ok_nxt;
  logic                    was_new_r, was_new_nxt;
  logic [AW-1:0]           a_r, a_nxt;
  logic [AW-1:0]           b_r, b_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [VERTEX_COUNT-1:0] key_r, key_nxt;
  logic                    undirected_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_reachable_r, out_reachable_nxt;
  logic                    out_edge_was_new_r, out_edge_was_new_nxt;

  logic [VERTEX_COUNT-1:0] adj_vld_r;
  logic [VERTEX_COUNT-1:0] reach_vld_r;
  logic                    adj_hit_r;
  logic                    reach_hit_r;
  logic [AW-1:0]           reach_rd_addr_r;

  logic                    in_ok;
  logic [AW-1:0]           idx_inc;
  logic                    sweep_hit;

  logic [AW-1:0]           adj_rd_addr, adj_wr_addr;
  logic [AW-1:0]           reach_rd_addr, reach_wr_addr;
  logic                    adj_we, reach_we;
  logic [VERTEX_COUNT-1:0] adj_wr_data, reach_wr_data;
  logic [VERTEX_COUNT-1:0] adj_rd_data, reach_rd_data;
  logic [VERTEX_COUNT-1:0] adj_row, reach_row;

  itc_ram #(.DEPTH(VERTEX_COUNT), .WIDTH(VERTEX_COUNT)) u_adj_ram (
    .clk     (clk),
    .wr_en   (adj_we),
    .wr_addr (adj_wr_addr),
    .wr_data (adj_wr_data),
    .rd_addr (adj_rd_addr),
    .rd_data (adj_rd_data)
  );

  itc_ram #(.DEPTH(VERTEX_COUNT), .WIDTH(VERTEX_COUNT)) u_reach_ram (
    .clk     (clk),
    .wr_en   (reach_we),
    .wr_addr (reach_wr_addr),
    .wr_data (reach_wr_data),
    .rd_addr (reach_rd_addr),
    .rd_data (reach_rd_data)
  );

  // Rows never written since reset read as their reset value.
  assign adj_row   = adj_hit_r ? adj_rd_data : '0;
  assign reach_row = reach_hit_r ? reach_rd_data : (ROW_ONE << reach_rd_addr_r);

  assign in_ok = (32'(in_source_vertex) < 32'(VERTEX_COUNT)) &&
                 (32'(in_target_vertex) < 32'(VERTEX_COUNT));

  assign idx_inc = (idx_r == LAST) ? '0 : idx_r + 1'b1;

  // Warshall step k takes every row holding bit k; an insert sweep takes rows that reach
  // the edge start but not yet the edge end.
  assign sweep_hit = (phase_r == PH_CLOSE) ? reach_row[b_r]
                                           : (reach_row[a_r] & ~reach_row[b_r]);

  always_comb begin
    state_nxt            = state_r;
    phase_nxt            = phase_r;
    kind_nxt             = kind_r;
    src_nxt              = src_r;
    tgt_nxt              = tgt_r;
    ok_nxt               = ok_r;
    was_new_nxt          = was_new_r;
    a_nxt                = a_r;
    b_nxt                = b_r;
    idx_nxt              = idx_r;
    key_nxt              = key_r;
    out_valid_nxt        = 1'b0;
    out_reachable_nxt    = out_reachable_r;
    out_edge_was_new_nxt = out_edge_was_new_r;
    adj_rd_addr          = src_r;
    reach_rd_addr        = src_r;
    adj_we               = 1'b0;
    adj_wr_addr          = src_r;
    adj_wr_data          = adj_row;
    reach_we             = 1'b0;
    reach_wr_addr        = idx_r;
    reach_wr_data        = reach_row | key_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt    = in_kind;
          src_nxt     = AW'(in_source_vertex);
          tgt_nxt     = AW'(in_target_vertex);
          ok_nxt      = in_ok;
          was_new_nxt = 1'b0;
          unique case (in_kind)
            KIND_INSERT:    state_nxt = in_ok ? ST_FWD_ADJ : ST_RES_RD;
            KIND_QUERY:     state_nxt = ST_RES_RD;
            KIND_RECOMPUTE: state_nxt = ST_INIT_PRE;
            default:        state_nxt = ST_RES_RD;
          endcase
        end
      end
      ST_FWD_ADJ: begin
        adj_rd_addr = src_r;
        state_nxt   = ST_FWD_CHK;
      end
      ST_FWD_CHK: begin
        if (!adj_row[tgt_r]) begin
          adj_we      = 1'b1;
          adj_wr_addr = src_r;
          adj_wr_data = adj_row | (ROW_ONE << tgt_r);
          was_new_nxt = 1'b1;
          phase_nxt   = PH_FWD;
          a_nxt       = src_r;
          b_nxt       = tgt_r;
          state_nxt   = ST_KEY;
        end else begin
          state_nxt = undirected_r ? ST_REV_ADJ : ST_RES_RD;
        end
      end
      ST_REV_ADJ: begin
        adj_rd_addr = tgt_r;
        state_nxt   = ST_REV_CHK;
      end
      ST_REV_CHK: begin
        if (!adj_row[src_r]) begin
          adj_we      = 1'b1;
          adj_wr_addr = tgt_r;
          adj_wr_data = adj_row | (ROW_ONE << src_r);
          was_new_nxt = 1'b1;
        end
        phase_nxt = PH_REV;
        a_nxt     = tgt_r;
        b_nxt     = src_r;
        state_nxt = ST_KEY;
      end
      ST_INIT_PRE: begin
        adj_rd_addr = '0;
        idx_nxt     = '0;
        state_nxt   = ST_INIT;
      end
      ST_INIT: begin
        reach_we      = 1'b1;
        reach_wr_addr = idx_r;
        reach_wr_data = adj_row | (ROW_ONE << idx_r);
        adj_rd_addr   = idx_inc;
        idx_nxt       = idx_inc;
        if (idx_r == LAST) begin
          phase_nxt = PH_CLOSE;
          b_nxt     = '0;
          state_nxt = ST_KEY;
        end
      end
      ST_KEY: begin
        reach_rd_addr = b_r;
        state_nxt     = ST_KEY_LAT;
      end
      ST_KEY_LAT: begin
        key_nxt       = reach_row;
        reach_rd_addr = '0;
        idx_nxt       = '0;
        state_nxt     = ST_SWEEP;
      end
      ST_SWEEP: begin
        // Row idx is written while row idx+1 is read, so the two never collide.
        reach_we      = sweep_hit;
        reach_wr_addr = idx_r;
        reach_wr_data = reach_row | key_r;
        reach_rd_addr = idx_inc;
        idx_nxt       = idx_inc;
        if (idx_r == LAST) begin
          unique case (phase_r)
            PH_FWD:   state_nxt = undirected_r ? ST_REV_ADJ : ST_RES_RD;
            PH_REV:   state_nxt = ST_RES_RD;
            PH_CLOSE: begin
              if (b_r == LAST) begin
                state_nxt = ST_RES_RD;
              end else begin
                b_nxt     = b_r + 1'b1;
                state_nxt = ST_KEY;
              end
            end
            default:  state_nxt = ST_RES_RD;
          endcase
        end
      end
      ST_RES_RD: begin
        reach_rd_addr = src_r;
        state_nxt     = ST_RES;
      end
      ST_RES: begin
        out_valid_nxt        = 1'b1;
        out_reachable_nxt    = ok_r & reach_row[tgt_r];
        out_edge_was_new_nxt = was_new_r;
        state_nxt            = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_FWD;
      undirected_r <= 1'b0;
      out_valid_r  <= 1'b0;
      adj_vld_r    <= '0;
      reach_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        undirected_r <= cfg_wr_data;
      end
      if (adj_we) begin
        adj_vld_r[adj_wr_addr] <= 1'b1;
      end
      if (reach_we) begin
        reach_vld_r[reach_wr_addr] <= 1'b1;
      end
    end
    kind_r             <= kind_nxt;
    src_r              <= src_nxt;
    tgt_r              <= tgt_nxt;
    ok_r               <= ok_nxt;
    was_new_r          <= was_new_nxt;
    a_r                <= a_nxt;
    b_r                <= b_nxt;
    idx_r              <= idx_nxt;
    key_r              <= key_nxt;
    out_reachable_r    <= out_reachable_nxt;
    out_edge_was_new_r <= out_edge_was_new_nxt;
    adj_hit_r          <= adj_vld_r[adj_rd_addr];
    reach_hit_r        <= reach_vld_r[reach_rd_addr];
    reach_rd_addr_r    <= reach_rd_addr;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_reachable    = out_reachable_r;
  assign out_edge_was_new = out_edge_was_new_r;

  // A result transfer comes in the cycle after the answer is formed.
  a_res_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RES) |=> out_valid)
    else $error("result strobe missing after answer state");

  a_res_only_from_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_RES))
    else $error("result strobe without answer state");

  // Only an insert can report a new edge.
  a_new_edge_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_edge_was_new) |-> (kind_r == KIND_INSERT))
    else $error("new edge reported for a command that is not an insert");

  // Neither matrix changes while the block is idle.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!adj_we && !reach_we))
    else $error("matrix write while idle");

endmodule
